// File: rtl/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types, sizes and codes of the minimum priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

    // Queue size and derived widths
    localparam int CAPACITY = 16;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int FILL_W   = 5;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // One stored entry
    typedef struct packed {
        logic signed [DATA_W-1:0] pri;
        logic signed [DATA_W-1:0] val;
    } entry_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

endpackage

// File: rtl/min_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// min_priority_queue_unit
// Bounded priority queue; the smallest priority number leaves first.
// ----------------------------------------------------------------------------
//  channel | handshake          | word
//  --------+--------------------+-------------------------------------------
//  input   | start & !busy      | op, item_value, item_priority
//  result  | done (one cycle)   | status, out_value, out_priority, fill_count
//
//  Each item is first captured as a word, then compared against all sixteen
//  slots in parallel while the sorted register file shifts.
//  done pulses the cycle after execute; a new word may be taken in that cycle.
//  Reset empties the queue; slot contents are only read once written.
//  The receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
module min_priority_queue_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  op,
    input  logic signed [mpq_pkg::DATA_W-1:0]     item_value,
    input  logic signed [mpq_pkg::DATA_W-1:0]     item_priority,
    output logic                                  done,
    output logic        [mpq_pkg::STATUS_W-1:0]   status,
    output logic signed [mpq_pkg::DATA_W-1:0]     out_value,
    output logic signed [mpq_pkg::DATA_W-1:0]     out_priority,
    output logic        [mpq_pkg::FILL_W-1:0]     fill_count
);
    import mpq_pkg::*;

    cmd_t cmd;

    // Sequencer
    mpq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // Sorted storage and result registers
    mpq_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .op            (op),
        .item_value    (item_value),
        .item_priority (item_priority),
        .status        (status),
        .out_value     (out_value),
        .out_priority  (out_priority),
        .fill_count    (fill_count)
    );

endmodule

// File: rtl/mpq_ctrl.sv
// ----------------------------------------------------------------------------
// mpq_ctrl
// Sequencer: takes a word in, runs one execute cycle, strobes the result.
// ----------------------------------------------------------------------------
module mpq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output logic          done,
    output mpq_pkg::cmd_t cmd
);
    import mpq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    // Decode commands from the current state
    always_comb
    begin
        cmd.load = start && (state_reg == S_IDLE);
        cmd.exec = (state_reg == S_EXEC);
        busy     = (state_reg == S_EXEC);
        done     = done_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance state and raise the result strobe after execute
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.exec;
        end
    end

endmodule

// File: rtl/mpq_dpath.sv
// ----------------------------------------------------------------------------
// mpq_dpath
// Sorted shift-register queue with parallel compare and result registers.
// ----------------------------------------------------------------------------
module mpq_dpath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  mpq_pkg::cmd_t                         cmd,
    input  logic                                  op,
    input  logic signed [mpq_pkg::DATA_W-1:0]     item_value,
    input  logic signed [mpq_pkg::DATA_W-1:0]     item_priority,
    output logic        [mpq_pkg::STATUS_W-1:0]   status,
    output logic signed [mpq_pkg::DATA_W-1:0]     out_value,
    output logic signed [mpq_pkg::DATA_W-1:0]     out_priority,
    output logic        [mpq_pkg::FILL_W-1:0]     fill_count
);
    import mpq_pkg::*;

    // Captured word
    logic                     op_reg;
    entry_t                   fresh_reg;

    // Queue storage, slot 0 holds the head
    entry_t                   ent_reg  [CAPACITY];
    entry_t                   ent_next [CAPACITY];
    logic [COUNT_W-1:0]       count_reg;
    logic [COUNT_W-1:0]       count_next;

    // Result registers
    logic [STATUS_W-1:0]      status_reg;
    logic [STATUS_W-1:0]      status_next;
    entry_t                   res_reg;
    entry_t                   res_next;

    logic                     full;
    logic                     empty;
    logic [CAPACITY-1:0]      gt;

    assign full  = (count_reg == COUNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    // Compare every held entry against the new priority
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            gt[i] = (COUNT_W'(i) < count_reg) && (ent_reg[i].pri > fresh_reg.pri);
        end
    end

    // Work out the next queue contents and the result
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            ent_next[i] = ent_reg[i];
        end
        count_next  = count_reg;
        status_next = ST_DONE;
        res_next    = '0;
        if (op_reg == OP_INSERT)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                // Shift larger priorities up one slot, drop the word in the gap
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (i > 0 && gt[(i > 0) ? i - 1 : 0])
                    begin
                        ent_next[i] = ent_reg[(i > 0) ? i - 1 : 0];
                    end
                    else if (gt[i] || (COUNT_W'(i) == count_reg))
                    begin
                        ent_next[i] = fresh_reg;
                    end
                end
                count_next = count_reg + 1'b1;
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                // Hand out the head and shift the rest down
                res_next = ent_reg[0];
                for (int i = 0; i < CAPACITY - 1; i++)
                begin
                    ent_next[i] = ent_reg[i + 1];
                end
                count_next = count_reg - 1'b1;
            end
        end
    end

    // Capture the incoming word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg        <= op;
            fresh_reg.pri <= item_priority;
            fresh_reg.val <= item_value;
        end
    end

    // Update storage and results on execute
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                ent_reg[i] <= ent_next[i];
            end
            status_reg <= status_next;
            res_reg    <= res_next;
        end
    end

    // Hold the fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    assign status       = status_reg;
    assign out_value    = res_reg.val;
    assign out_priority = res_reg.pri;
    assign fill_count   = FILL_W'(count_reg);

endmodule

// File: tb/tb_min_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// tb_min_priority_queue_unit
// Self-checking bench for the minimum priority queue. A short directed table
// covers the empty, full, tie-order and extreme cases. A random sequence with
// shifting insert/remove mix follows and fills and drains the queue many times.
// Each accepted word updates a shadow sorted queue that predicts the result
// word. Result words are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_min_priority_queue_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import mpq_pkg::*;

    localparam int RANDOM_WORDS = 400;
    localparam int DIR_ROWS     = 16;
    localparam int SETTLE       = 6;

    localparam logic signed [DATA_W-1:0] MAX32 = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] MIN32 = 32'sh8000_0000;

    // One result word
    typedef struct packed {
        logic        [STATUS_W-1:0] status;
        logic signed [DATA_W-1:0]   val;
        logic signed [DATA_W-1:0]   pri;
        logic        [FILL_W-1:0]   fill;
    } result_t;

    // One row of the directed table; typed rows carry their own result word
    typedef struct {
        logic                     op;
        logic signed [DATA_W-1:0] val;
        logic signed [DATA_W-1:0] pri;
        int                       reps;
        bit                       typed;
        result_t                  want;
    } stim_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic                       op;
    logic signed [DATA_W-1:0]   item_value;
    logic signed [DATA_W-1:0]   item_priority;
    logic                       done;
    logic        [STATUS_W-1:0] status;
    logic signed [DATA_W-1:0]   out_value;
    logic signed [DATA_W-1:0]   out_priority;
    logic        [FILL_W-1:0]   fill_count;

    // Side channel from the driver: typed expectation of the current word
    bit      row_typed;
    result_t row_want;

    entry_t  shadow_q [$];
    result_t awaited_results [$];
    int      mismatch_count;

    int unsigned insert_bias [8] = '{85, 15, 50, 90, 10, 60, 75, 25};

    stim_row_t dir_rows [DIR_ROWS] = '{
        '{OP_REMOVE, 0,      0,      1,  1'b1, '{ST_EMPTY, 0, 0, 0}},
        '{OP_INSERT, MAX32,  MAX32,  1,  1'b1, '{ST_DONE, 0, 0, 1}},
        '{OP_INSERT, MIN32,  MIN32,  1,  1'b1, '{ST_DONE, 0, 0, 2}},
        '{OP_INSERT, 5,      0,      1,  1'b0, '{ST_DONE, 0, 0, 0}},
        '{OP_INSERT, 6,      0,      1,  1'b0, '{ST_DONE, 0, 0, 0}},
        '{OP_INSERT, 7,      -1,     1,  1'b0, '{ST_DONE, 0, 0, 0}},
        '{OP_REMOVE, 0,      0,      1,  1'b1, '{ST_DONE, MIN32, MIN32, 4}},
        '{OP_REMOVE, -1,     -1,     3,  1'b0, '{ST_DONE, 0, 0, 0}},
        '{OP_REMOVE, 0,      0,      1,  1'b1, '{ST_DONE, MAX32, MAX32, 0}},
        '{OP_REMOVE, MAX32,  MIN32,  1,  1'b1, '{ST_EMPTY, 0, 0, 0}},
        '{OP_INSERT, 100,    3,      16, 1'b0, '{ST_DONE, 0, 0, 0}},
        '{OP_INSERT, -1,     MIN32,  1,  1'b1, '{ST_FULL, 0, 0, 16}},
        '{OP_REMOVE, 0,      0,      16, 1'b0, '{ST_DONE, 0, 0, 0}},
        '{OP_REMOVE, 0,      0,      1,  1'b1, '{ST_EMPTY, 0, 0, 0}},
        '{OP_INSERT, -1,     -1,     1,  1'b1, '{ST_DONE, 0, 0, 1}},
        '{OP_REMOVE, 0,      0,      1,  1'b1, '{ST_DONE, -1, -1, 0}}
    };

    min_priority_queue_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .item_value    (item_value),
        .item_priority (item_priority),
        .done          (done),
        .status        (status),
        .out_value     (out_value),
        .out_priority  (out_priority),
        .fill_count    (fill_count)
    );

    // Free-running clock, 20 ns period
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Apply one word to the shadow queue and return its result word
    function automatic result_t apply_to_shadow_queue(input logic o,
                                                      input logic signed [DATA_W-1:0] v,
                                                      input logic signed [DATA_W-1:0] p);
        result_t r;
        entry_t  e;
        int      slot;
        r.status = ST_DONE;
        r.val    = '0;
        r.pri    = '0;
        if (o == OP_INSERT)
        begin
            if (shadow_q.size() >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                // place after every held entry with the same or lower priority
                e.pri = p;
                e.val = v;
                slot  = 0;
                while (slot < shadow_q.size() && shadow_q[slot].pri <= p)
                    slot++;
                shadow_q.insert(slot, e);
            end
        end
        else if (shadow_q.size() == 0)
            r.status = ST_EMPTY;
        else
        begin
            r.val = shadow_q[0].val;
            r.pri = shadow_q[0].pri;
            void'(shadow_q.pop_front());
        end
        r.fill = FILL_W'(shadow_q.size());
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint got,
                                   input longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
        mismatch_count++;
    endtask

    // Check result words, then record the word accepted at this edge
    always @(posedge clk)
    begin : watch_results
        result_t want;
        result_t pred;
        if (rst_n)
        begin
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    // result word with none outstanding
                    report_mismatch("done", longint'(1), longint'(0));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", longint'(status), longint'(want.status));
                    if (out_value !== want.val)
                        report_mismatch("out_value", longint'(out_value), longint'(want.val));
                    if (out_priority !== want.pri)
                        report_mismatch("out_priority", longint'(out_priority),
                                        longint'(want.pri));
                    if (fill_count !== want.fill)
                        report_mismatch("fill_count", longint'(fill_count),
                                        longint'(want.fill));
                end
            end
            if (start && !busy)
            begin
                pred = apply_to_shadow_queue(op, item_value, item_priority);
                awaited_results.push_back(row_typed ? row_want : pred);
            end
        end
    end

    // Hold one word on the inputs until it is taken
    task automatic drive_word(input logic o, input logic signed [DATA_W-1:0] v,
                              input logic signed [DATA_W-1:0] p, input bit typed,
                              input result_t want);
        start         <= 1'b1;
        op            <= o;
        item_value    <= v;
        item_priority <= p;
        row_typed     <= typed;
        row_want      <= want;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // Now and then drop start for a while, with noise on the fields
    task automatic maybe_idle(input bit allow);
        if (allow && $urandom_range(99) < 8)
        begin
            start         <= 1'b0;
            op            <= 1'($urandom_range(1));
            item_value    <= $urandom();
            item_priority <= $urandom();
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_extreme();
        case ($urandom_range(3))
            0: return MIN32;
            1: return MAX32;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    // Stimulus: reset, directed table, random sequence, drain
    initial
    begin
        int                       n;
        int                       k;
        int                       sel;
        logic                     o;
        logic signed [DATA_W-1:0] v;
        logic signed [DATA_W-1:0] p;
        result_t                  none;
        none           = '0;
        mismatch_count = 0;
        rst_n          = 1'b0;
        start          = 1'b0;
        op             = OP_INSERT;
        item_value     = '0;
        item_priority  = '0;
        row_typed      = 1'b0;
        row_want       = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // walk the directed table
        for (n = 0; n < DIR_ROWS; n++)
        begin
            for (k = 0; k < dir_rows[n].reps; k++)
            begin
                drive_word(dir_rows[n].op, dir_rows[n].val + k, dir_rows[n].pri,
                           dir_rows[n].typed, dir_rows[n].want);
                maybe_idle(1'b1);
            end
        end

        // random words; insert mix shifts every 50 words to fill and drain
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            o   = ($urandom_range(99) < insert_bias[(n / 50) % 8]) ? OP_INSERT : OP_REMOVE;
            sel = $urandom_range(9);
            if (sel < 6)
                p = $signed($urandom_range(6)) - 3;
            else if (sel < 9)
                p = $urandom();
            else
                p = pick_extreme();
            v = ($urandom_range(9) == 0) ? pick_extreme() : $signed($urandom());
            drive_word(o, v, p, 1'b0, none);
            if (n == 300)
            begin
                // hold off until every outstanding result word is back
                start <= 1'b0;
                do
                    @(negedge clk);
                while (awaited_results.size() != 0);
            end
            else
                maybe_idle(n < 120 || n >= 220);
        end

        // drain and let the pipeline settle
        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: min_priority_queue_unit.f
rtl/mpq_pkg.sv
rtl/mpq_ctrl.sv
rtl/mpq_dpath.sv
rtl/min_priority_queue_unit.sv
tb/tb_min_priority_queue_unit.sv
